### rtl/dq_pkg.sv
package dq_pkg;

  localparam int CAPACITY   = 256;
  localparam int DATA_W     = 32;
  localparam int ADDR_W     = $clog2(CAPACITY);
  localparam int CNT_W      = ADDR_W + 1;
  localparam int OP_W       = 3;
  localparam int POS_W      = 8;
  localparam int OCC_W      = 9;
  localparam int ST_W       = 2;

  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
  localparam logic [OP_W-1:0] OP_READ       = 3'd4;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd3;

  typedef logic [DATA_W-1:0] data_t;
  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [OP_W-1:0]   op_t;
  typedef logic [POS_W-1:0]  pos_t;
  typedef logic [OCC_W-1:0]  occ_t;
  typedef logic [ST_W-1:0]   status_t;

  typedef struct packed {
    logic  we;
    logic  re;
    addr_t addr;
    data_t wdata;
  } mem_req_t;

  typedef struct packed {
    logic    rd;
    cnt_t    count;
    status_t status;
  } meta_t;

endpackage

### rtl/dq_if.sv
interface dq_in_if;
  import dq_pkg::*;
  logic  valid;
  logic  ready;
  op_t   opcode;
  data_t push_value;
  pos_t  position;

  modport source (output valid, output opcode, output push_value, output position,
                  input ready);
  modport sink   (input valid, input opcode, input push_value, input position,
                  output ready);
endinterface

interface dq_out_if;
  import dq_pkg::*;
  logic    valid;
  logic    ready;
  data_t   element;
  occ_t    occupancy;
  logic    is_empty;
  status_t status;

  modport source (output valid, output element, output occupancy, output is_empty,
                  output status, input ready);
  modport sink   (input valid, input element, input occupancy, input is_empty,
                  input status, output ready);
endinterface

### rtl/dq_ram.sv
module dq_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/dq_ctrl.sv
module dq_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  dq_pkg::op_t      opcode,
  input  dq_pkg::data_t    push_value,
  input  dq_pkg::pos_t     position,
  output dq_pkg::mem_req_t mem_req,
  output dq_pkg::meta_t    meta
);
  import dq_pkg::*;

  addr_t head_r, head_nxt;
  cnt_t  count_r, count_nxt;
  logic  full, empty;
  cnt_t  pos_ext;
  addr_t cnt_lo, pos_lo;
  mem_req_t req;
  status_t  st;
  logic     rd;

  assign full    = (count_r == cnt_t'(CAPACITY));
  assign empty   = (count_r == '0);
  assign pos_ext = cnt_t'(position);
  assign cnt_lo  = count_r[ADDR_W-1:0];
  assign pos_lo  = pos_ext[ADDR_W-1:0];

  always_comb begin
    head_nxt  = head_r;
    count_nxt = count_r;
    req.we    = 1'b0;
    req.re    = 1'b0;
    req.addr  = head_r;
    req.wdata = push_value;
    st        = ST_OK;
    rd        = 1'b0;
    case (opcode)
      OP_PUSH_FRONT: begin
        if (full) begin
          st = ST_FULL;
        end else begin
          req.we    = 1'b1;
          req.addr  = head_r - addr_t'(1);
          head_nxt  = head_r - addr_t'(1);
          count_nxt = count_r + cnt_t'(1);
        end
      end
      OP_PUSH_BACK: begin
        if (full) begin
          st = ST_FULL;
        end else begin
          req.we    = 1'b1;
          req.addr  = head_r + cnt_lo;
          count_nxt = count_r + cnt_t'(1);
        end
      end
      OP_POP_FRONT: begin
        if (empty) begin
          st = ST_EMPTY;
        end else begin
          req.re    = 1'b1;
          rd        = 1'b1;
          head_nxt  = head_r + addr_t'(1);
          count_nxt = count_r - cnt_t'(1);
        end
      end
      OP_POP_BACK: begin
        if (empty) begin
          st = ST_EMPTY;
        end else begin
          req.re    = 1'b1;
          rd        = 1'b1;
          req.addr  = head_r + cnt_lo - addr_t'(1);
          count_nxt = count_r - cnt_t'(1);
        end
      end
      OP_READ: begin
        if (pos_ext >= count_r) begin
          st = ST_RANGE;
        end else begin
          req.re   = 1'b1;
          rd       = 1'b1;
          req.addr = head_r + pos_lo;
        end
      end
      default: begin
      end
    endcase
  end

  // nothing reaches memory or pointers unless the transaction is taken
  always_comb begin
    mem_req     = req;
    mem_req.we  = req.we & accept;
    mem_req.re  = req.re & accept;
    meta.rd     = rd;
    meta.count  = count_nxt;
    meta.status = st;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
    end else if (accept) begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

### rtl/double_ended_queue.sv
// double-ended queue of 256 32-bit elements, held in a ring buffer memory
// input channel in_ch: opcode (push front/back, pop front/back, read at
//   position), push_value and position; one transaction per request
// output channel out_ch: one result per request with the popped or read
//   element, occupancy and empty flag after the request, and a status code
// a refused request (push when full, pop when empty, read past the count)
//   gives a nonzero status, element zero and leaves the queue unchanged
// the memory read happens at the edge that takes the request and the output
//   register loads from the read data once the output stage can advance
// throughput: one request per cycle unless the output stalls, set by the
//   single write port and single read port of the slot memory, each used
//   at most once per request
// head pointer and count update at acceptance, so a pop right after a push
//   reads the slot the push wrote on the previous edge
// reset clears head and count; the slot memory needs no clearing pass
// when the receiver stalls, the result holds in the output register, one more
//   request may be taken into the memory read stage, then in_ch.ready drops
module double_ended_queue (
  input  logic     clk,
  input  logic     rst_n,
  dq_in_if.sink    in_ch,
  dq_out_if.source out_ch
);
  import dq_pkg::*;

  logic     accept;
  logic     s1_adv;
  mem_req_t mem_req;
  meta_t    meta;
  data_t    rdata;

  logic    s1_v_r, s1_v_nxt;
  meta_t   s1_meta_r;
  logic    out_v_r, out_v_nxt;
  data_t   out_elem_r;
  cnt_t    out_cnt_r;
  status_t out_st_r;

  assign s1_adv      = !out_v_r || out_ch.ready;
  assign in_ch.ready = !s1_v_r || s1_adv;
  assign accept      = in_ch.valid && in_ch.ready;

  dq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .opcode     (in_ch.opcode),
    .push_value (in_ch.push_value),
    .position   (in_ch.position),
    .mem_req    (mem_req),
    .meta       (meta)
  );

  dq_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (DATA_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.addr),
    .wdata (mem_req.wdata),
    .re    (mem_req.re),
    .raddr (mem_req.addr),
    .rdata (rdata)
  );

  always_comb begin
    s1_v_nxt  = s1_v_r;
    out_v_nxt = out_v_r;
    if (in_ch.ready) begin
      s1_v_nxt = accept;
    end
    if (s1_adv) begin
      out_v_nxt = s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_meta_r <= meta;
    end
    if (s1_adv && s1_v_r) begin
      out_elem_r <= s1_meta_r.rd ? rdata : '0;
      out_cnt_r  <= s1_meta_r.count;
      out_st_r   <= s1_meta_r.status;
    end
  end

  assign out_ch.valid     = out_v_r;
  assign out_ch.element   = out_elem_r;
  assign out_ch.occupancy = occ_t'(out_cnt_r);
  assign out_ch.is_empty  = (out_cnt_r == '0);
  assign out_ch.status    = out_st_r;

endmodule

### rtl/dq_checker.sv
module dq_checker (
  input logic            clk,
  input logic            rst_n,
  input logic            out_valid,
  input logic            out_ready,
  input dq_pkg::data_t   out_element,
  input dq_pkg::occ_t    out_occupancy,
  input logic            out_is_empty,
  input dq_pkg::status_t out_status
);
  import dq_pkg::*;

  // a stalled result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_element)
      && $stable(out_occupancy) && $stable(out_status))
    else $error("result changed while stalled");

  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_is_empty == (out_occupancy == '0))
    else $error("empty flag disagrees with occupancy");

  a_full_push: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_FULL |-> out_occupancy == occ_t'(CAPACITY))
    else $error("full status with queue not full");

  a_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_EMPTY |-> out_is_empty)
    else $error("empty status with queue not empty");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_element == '0)
    else $error("refused request returned an element");

endmodule

bind double_ended_queue dq_checker u_dq_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_element   (out_ch.element),
  .out_occupancy (out_ch.occupancy),
  .out_is_empty  (out_ch.is_empty),
  .out_status    (out_ch.status)
);

### test/tb_top.sv
module tb_top;
  import dq_pkg::*;

  localparam op_t OP_UNUSED_LO  = OP_READ + 1'b1;
  localparam op_t OP_UNUSED_HI  = '1;
  localparam int  POS_MAX       = (1 << POS_W) - 1;
  localparam int  LONG_HOLD     = 80;
  localparam int  WATCHDOG_MAX  = 5000;
  localparam int  SETTLE_CYCLES = 20;
  localparam int  MAX_REPORTS   = 10;

  typedef struct packed {
    op_t   opcode;
    data_t push_value;
    pos_t  position;
  } dq_request_t;

  typedef struct packed {
    data_t   element;
    occ_t    occupancy;
    logic    is_empty;
    status_t status;
  } dq_result_t;

  logic clk;
  logic rst_n;

  dq_in_if  in_ch();
  dq_out_if out_ch();

  double_ended_queue DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  dq_request_t pending_requests[$];
  dq_result_t  expected_results[$];

  // shadow copy of the ring buffer, updated when a request transaction is taken
  data_t ring_shadow [CAPACITY];
  addr_t front_slot;
  cnt_t  fill_level;

  // occupancy as seen by the stimulus generator, at queueing time
  int unsigned gen_level;

  int unsigned send_gap_pct = 13;
  int unsigned take_gap_pct = 54;
  int unsigned stall_ticket = 0;
  int unsigned stall_served;
  int unsigned hold_left;
  int unsigned idle_cycles;

  int unsigned requests_taken  = 0;
  int unsigned results_checked = 0;
  int unsigned mismatches      = 0;
  int unsigned peak_level      = 0;
  int unsigned full_refusals   = 0;
  int unsigned empty_refusals  = 0;
  int unsigned range_refusals  = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic dq_result_t apply_request(dq_request_t req);
    dq_result_t res;
    res = '0;
    res.status = ST_OK;
    case (req.opcode)
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (fill_level == CAPACITY) begin
          res.status = ST_FULL;
        end else begin
          if (req.opcode == OP_PUSH_FRONT) begin
            front_slot = front_slot - 1'b1;
            ring_shadow[front_slot] = req.push_value;
          end else begin
            ring_shadow[addr_t'(front_slot + fill_level)] = req.push_value;
          end
          fill_level = fill_level + 1'b1;
        end
      end
      OP_POP_FRONT: begin
        if (fill_level == 0) begin
          res.status = ST_EMPTY;
        end else begin
          res.element = ring_shadow[front_slot];
          front_slot = front_slot + 1'b1;
          fill_level = fill_level - 1'b1;
        end
      end
      OP_POP_BACK: begin
        if (fill_level == 0) begin
          res.status = ST_EMPTY;
        end else begin
          res.element = ring_shadow[addr_t'(front_slot + fill_level - 1'b1)];
          fill_level = fill_level - 1'b1;
        end
      end
      OP_READ: begin
        if (req.position >= fill_level) begin
          res.status = ST_RANGE;
        end else begin
          res.element = ring_shadow[addr_t'(front_slot + req.position)];
        end
      end
      default: begin
      end
    endcase
    res.occupancy = fill_level;
    res.is_empty  = (fill_level == 0);
    if (fill_level > peak_level) peak_level = fill_level;
    case (res.status)
      ST_FULL:  full_refusals++;
      ST_EMPTY: empty_refusals++;
      ST_RANGE: range_refusals++;
      default: begin
      end
    endcase
    return res;
  endfunction

  // request driver: predicts on each accepted transaction, then offers the next one
  always @(posedge clk) begin : drive_requests
    dq_request_t next_req;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expected_results.push_back(
          apply_request({in_ch.opcode, in_ch.push_value, in_ch.position}));
        requests_taken++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_requests.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
          next_req = pending_requests.pop_front();
          in_ch.valid      <= 1'b1;
          in_ch.opcode     <= next_req.opcode;
          in_ch.push_value <= next_req.push_value;
          in_ch.position   <= next_req.position;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver back-pressure
  always @(posedge clk) begin : check_results
    dq_result_t got;
    dq_result_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      hold_left    <= 0;
      stall_served <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.element, out_ch.occupancy, out_ch.is_empty, out_ch.status};
        results_checked++;
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("unexpected result: element %h occupancy %0d empty %b status %0d",
                     got.element, got.occupancy, got.is_empty, got.status);
        end else begin
          want = expected_results.pop_front();
          if (got.element !== want.element || got.occupancy !== want.occupancy ||
              got.is_empty !== want.is_empty || got.status !== want.status) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("mismatch on result %0d: element exp %h got %h, occupancy exp %0d got %0d,%s",
                       results_checked, want.element, got.element,
                       want.occupancy, got.occupancy,
                       $sformatf(" empty exp %b got %b, status exp %0d got %0d",
                                 want.is_empty, got.is_empty, want.status, got.status));
          end
        end
      end
      if (stall_ticket != stall_served) begin
        stall_served <= stall_ticket;
        hold_left    <= LONG_HOLD;
        out_ch.ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left    <= hold_left - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= take_gap_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_MAX) begin
      $display("timeout: no transaction for %0d cycles, %0d results outstanding",
               WATCHDOG_MAX, expected_results.size());
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic queue_request(op_t op, data_t value, pos_t pos);
    pending_requests.push_back('{op, value, pos});
    if ((op == OP_PUSH_FRONT || op == OP_PUSH_BACK) && gen_level < CAPACITY)
      gen_level++;
    else if ((op == OP_POP_FRONT || op == OP_POP_BACK) && gen_level > 0)
      gen_level--;
  endtask

  function automatic op_t random_push();
    return $urandom_range(1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
  endfunction

  function automatic op_t random_pop();
    return $urandom_range(1) ? OP_POP_BACK : OP_POP_FRONT;
  endfunction

  // mostly positions inside the queue, some anywhere in the field
  function automatic pos_t pick_position();
    if (gen_level != 0 && $urandom_range(9) < 8)
      return pos_t'($urandom_range(gen_level - 1));
    return pos_t'($urandom_range(POS_MAX));
  endfunction

  task automatic queue_random(int unsigned count, int unsigned push_pct);
    int unsigned roll;
    op_t op;
    repeat (count) begin
      roll = $urandom_range(99);
      if (roll < 3)
        op = op_t'($urandom_range(OP_UNUSED_HI, OP_UNUSED_LO));
      else if (roll < 3 + push_pct)
        op = random_push();
      else if (roll < 3 + push_pct + (97 - push_pct) * 2 / 3)
        op = random_pop();
      else
        op = OP_READ;
      queue_request(op, data_t'($urandom), pick_position());
    end
  endtask

  task automatic wait_all_done();
    do @(negedge clk);
    while (pending_requests.size() != 0 || in_ch.valid || expected_results.size() != 0);
  endtask

  initial begin : stimulus
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.opcode     = OP_PUSH_FRONT;
    in_ch.push_value = '0;
    in_ch.position   = '0;
    out_ch.ready     = 1'b0;
    front_slot       = '0;
    fill_level       = '0;
    gen_level        = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // refusals on an empty queue and ignored opcodes
    queue_request(OP_POP_FRONT, '0, '0);
    queue_request(OP_POP_BACK, '0, '0);
    queue_request(OP_READ, '0, '0);
    queue_request(OP_UNUSED_LO, '1, pos_t'(POS_MAX));
    queue_request(OP_UNUSED_HI, 32'h8000_0001, '0);
    // push front from head zero wraps to the top slot
    queue_request(OP_PUSH_FRONT, '1, '0);
    queue_request(OP_PUSH_BACK, '0, pos_t'(POS_MAX));
    queue_request(OP_PUSH_FRONT, 32'h8000_0001, '0);
    queue_request(OP_PUSH_BACK, 32'h7fff_ffff, '0);
    queue_request(OP_READ, '0, 8'd0);
    queue_request(OP_READ, '0, 8'd3);
    queue_request(OP_READ, '0, 8'd4);
    queue_request(OP_READ, '0, pos_t'(POS_MAX));
    queue_request(OP_POP_BACK, '0, '0);
    queue_request(OP_POP_FRONT, '0, '0);
    queue_request(OP_READ, '0, 8'd1);
    queue_request(OP_POP_FRONT, '0, '0);
    queue_request(OP_POP_BACK, '0, '0);
    queue_request(OP_POP_FRONT, '0, '0);
    // pop right behind the push that wrote the slot
    queue_request(OP_PUSH_BACK, 32'h5a5a_5a5a, '0);
    queue_request(OP_POP_FRONT, '0, '0);
    queue_request(OP_PUSH_FRONT, 32'ha5a5_a5a5, '0);
    queue_request(OP_POP_BACK, '0, '0);
    queue_request(OP_READ, '0, '0);
    wait_all_done();

    queue_random(100, 40);

    @(negedge clk);
    send_gap_pct = 54;
    take_gap_pct = 13;
    while (gen_level < CAPACITY)
      queue_request(random_push(), data_t'($urandom), pick_position());
    queue_request(OP_PUSH_FRONT, data_t'($urandom), '0);
    queue_request(OP_PUSH_BACK, data_t'($urandom), '0);
    queue_request(OP_READ, '0, pos_t'(POS_MAX));
    queue_request(OP_READ, '0, pos_t'(POS_MAX - 1));
    queue_request(OP_READ, '0, 8'd128);
    queue_request(OP_READ, '0, 8'd0);
    repeat (10) queue_request(OP_READ, '0, pos_t'($urandom_range(POS_MAX)));
    // hover at the full mark
    repeat (6) begin
      queue_request(random_pop(), '0, '0);
      queue_request(random_push(), data_t'($urandom), '0);
      queue_request(random_push(), data_t'($urandom), '0);
    end
    wait_all_done();

    // no idling, receiver holds off long enough to back up the input
    send_gap_pct = 0;
    take_gap_pct = 0;
    stall_ticket++;
    queue_random(60, 10);
    while (gen_level != 0)
      queue_request(random_pop(), '0, '0);
    queue_request(OP_POP_BACK, '0, '0);
    queue_request(OP_POP_FRONT, '0, '0);
    wait_all_done();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d requests and %0d results, peak occupancy %0d",
             requests_taken, results_checked, peak_level);
    $display("refusals: %0d full, %0d empty, %0d out of range; %0d mismatches",
             full_refusals, empty_refusals, range_refusals, mismatches);
    if (mismatches == 0 && expected_results.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

### sim.f
rtl/dq_pkg.sv
rtl/dq_if.sv
rtl/dq_ram.sv
rtl/dq_ctrl.sv
rtl/double_ended_queue.sv
rtl/dq_checker.sv
test/tb_top.sv
